### hw/rtl/length_framed_packet_deframer_top_macros.svh
// Assertion helpers for the deframer checker.
`ifndef LENGTH_FRAMED_PACKET_DEFRAMER_TOP_MACROS_SVH
`define LENGTH_FRAMED_PACKET_DEFRAMER_TOP_MACROS_SVH

// same-cycle implication
`define LFPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LFPD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/lfpd_pkg.sv
`default_nettype none
package lfpd_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN      = 2'd2;

  localparam logic [7:0]  START_MARKER_RST = 8'hAA;
  localparam logic [7:0]  END_MARKER_RST   = 8'hBB;
  localparam logic [15:0] MAX_LEN_RST      = 16'hFFFF;
  localparam logic [15:0] MIN_FRAME_LEN    = 16'd5;
  localparam logic [15:0] HDR_LEN          = 16'd4;
  localparam logic [15:0] LEAD_END_POS     = 16'd8;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_BAD_TAIL = 2'd2,
    KIND_BAD_LEN  = 2'd3
  } kind_t;

  // request from front to back
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  command;
    logic [7:0]  data;
    logic [15:0] pos;
    logic [15:0] frame_len;
    logic [31:0] lead;
  } req_t;

endpackage
`default_nettype wire

### hw/rtl/lfpd_front.sv
`default_nettype none
module lfpd_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_rx_byte,
  input  wire logic                          cfg_valid,
  input  wire logic [lfpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_data,
  input  wire logic                          q_full,
  output logic                               push,
  output lfpd_pkg::req_t                     push_req
);

  logic [7:0]  start_marker_r, end_marker_r;
  logic [15:0] max_len_r;
  logic        in_frame_r, in_frame_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [31:0] lead_r, lead_nxt;
  logic        acc;
  logic [15:0] len_full;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign len_full = {len_r[15:8], in_rx_byte};

  always_comb begin
    in_frame_nxt       = in_frame_r;
    count_nxt          = count_r;
    len_nxt            = len_r;
    cmd_nxt            = cmd_r;
    lead_nxt           = lead_r;
    push               = 1'b0;
    push_req.kind      = lfpd_pkg::KIND_PAYLOAD;
    push_req.command   = cmd_r;
    push_req.data      = in_rx_byte;
    push_req.pos       = count_r;
    push_req.frame_len = len_r;
    push_req.lead      = lead_r;
    if (acc) begin
      if (!in_frame_r) begin
        if (in_rx_byte == start_marker_r) begin
          in_frame_nxt = 1'b1;
          count_nxt    = 16'd1;
          len_nxt      = '0;
          cmd_nxt      = '0;
          lead_nxt     = '0;
        end
      end else begin
        count_nxt = count_r + 16'd1;
        case (count_r)
          16'd1: len_nxt = {in_rx_byte, 8'h00};
          16'd2: begin
            len_nxt = len_full;
            push_req.frame_len = len_full;
            if (len_full < lfpd_pkg::MIN_FRAME_LEN || len_full > max_len_r) begin
              in_frame_nxt  = 1'b0;
              push          = 1'b1;
              push_req.kind = lfpd_pkg::KIND_BAD_LEN;
            end
          end
          16'd3: cmd_nxt = in_rx_byte;
          default: begin
            push = 1'b1;
            if (count_r == len_r - 16'd1) begin
              in_frame_nxt  = 1'b0;
              push_req.kind = (in_rx_byte == end_marker_r) ? lfpd_pkg::KIND_GOOD
                                                           : lfpd_pkg::KIND_BAD_TAIL;
            end else if (count_r < lfpd_pkg::LEAD_END_POS) begin
              lead_nxt = {lead_r[23:0], in_rx_byte};
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r     <= 1'b0;
      count_r        <= '0;
      len_r          <= '0;
      cmd_r          <= '0;
      lead_r         <= '0;
      start_marker_r <= lfpd_pkg::START_MARKER_RST;
      end_marker_r   <= lfpd_pkg::END_MARKER_RST;
      max_len_r      <= lfpd_pkg::MAX_LEN_RST;
    end else begin
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
      len_r      <= len_nxt;
      cmd_r      <= cmd_nxt;
      lead_r     <= lead_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          lfpd_pkg::CFG_START_MARKER: start_marker_r <= cfg_data[7:0];
          lfpd_pkg::CFG_END_MARKER:   end_marker_r   <= cfg_data[7:0];
          lfpd_pkg::CFG_MAX_LEN:      max_len_r      <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/lfpd_queue.sv
`default_nettype none
module lfpd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire lfpd_pkg::req_t push_req,
  output logic                full,
  input  wire logic           pop,
  output logic                q_valid,
  output lfpd_pkg::req_t      q_req
);

  lfpd_pkg::req_t            slot_r [lfpd_pkg::Q_DEPTH];
  logic [lfpd_pkg::Q_AW-1:0] wptr_r, rptr_r;
  logic [lfpd_pkg::Q_AW:0]   cnt_r, cnt_nxt;
  logic                      do_push, do_pop;

  assign full    = (cnt_r == (lfpd_pkg::Q_AW+1)'(lfpd_pkg::Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_req   = slot_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wptr_r] <= push_req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop)  rptr_r <= rptr_r + 1'b1;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/lfpd_back.sv
`default_nettype none
module lfpd_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire lfpd_pkg::req_t q_req,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_command,
  output logic [7:0]          out_data,
  output logic [15:0]         out_payload_index,
  output logic [15:0]         out_frame_len,
  output logic [31:0]         out_lead_value
);

  logic        out_valid_r;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  command_r, data_r, data_nxt;
  logic [15:0] index_r, index_nxt, frame_len_r;
  logic [31:0] lead_r, lead_nxt;

  assign pop = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    kind_nxt  = q_req.kind;
    data_nxt  = '0;
    index_nxt = '0;
    lead_nxt  = '0;
    case (q_req.kind)
      lfpd_pkg::KIND_PAYLOAD: begin
        data_nxt  = q_req.data;
        index_nxt = q_req.pos - lfpd_pkg::HDR_LEN;
      end
      lfpd_pkg::KIND_GOOD, lfpd_pkg::KIND_BAD_TAIL: begin
        index_nxt = q_req.frame_len - lfpd_pkg::MIN_FRAME_LEN;
        lead_nxt  = q_req.lead;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r      <= kind_nxt;
      command_r   <= q_req.command;
      data_r      <= data_nxt;
      index_r     <= index_nxt;
      frame_len_r <= q_req.frame_len;
      lead_r      <= lead_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_command       = command_r;
  assign out_data          = data_r;
  assign out_payload_index = index_r;
  assign out_frame_len     = frame_len_r;
  assign out_lead_value    = lead_r;

endmodule
`default_nettype wire

### hw/rtl/length_framed_packet_deframer_top.sv
// Length-framed packet deframer. Takes one received byte per clock on the in_ channel while
// in_ready is high; the front-end parser updates its frame position, length, command and
// lead-value registers once per accepted byte. Payload bytes come out as they arrive, header
// bytes and stray bytes outside a frame give nothing, and each frame ends with one status
// request (good, bad end marker, or bad length once both length bytes are in). A result
// reaches out_ through a queue slot and then the output register; the four-entry queue
// between parser and output register absorbs output stalls, and in_ready drops only when
// that queue is full. Configuration writes are taken every cycle.
`default_nettype none
module length_framed_packet_deframer_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     in_rx_byte,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [1:0]                          out_kind,
  output logic [7:0]                          out_command,
  output logic [7:0]                          out_data,
  output logic [15:0]                         out_payload_index,
  output logic [15:0]                         out_frame_len,
  output logic [31:0]                         out_lead_value,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lfpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                    cfg_data
);

  logic           q_full, push, pop, q_valid;
  lfpd_pkg::req_t push_req, q_req;

  assign cfg_ready = 1'b1;

  lfpd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push       (push),
    .push_req   (push_req)
  );

  lfpd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_req    (q_req)
  );

  lfpd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_req             (q_req),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_command       (out_command),
    .out_data          (out_data),
    .out_payload_index (out_payload_index),
    .out_frame_len     (out_frame_len),
    .out_lead_value    (out_lead_value)
  );

endmodule
`default_nettype wire

### hw/rtl/lfpd_checker.sv
`default_nettype none
`include "length_framed_packet_deframer_top_macros.svh"
module lfpd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_kind,
  input wire logic [7:0]  out_command,
  input wire logic [7:0]  out_data,
  input wire logic [15:0] out_payload_index,
  input wire logic [15:0] out_frame_len,
  input wire logic [31:0] out_lead_value
);

  logic        stall;
  logic        is_end;
  logic        is_bad_len;
  logic        is_payload;
  logic [49:0] held_fields;
  logic        bad_len_clean;
  logic        end_clean;
  logic        payload_clean;

  assign stall         = out_valid && !out_ready;
  assign is_end        = (out_kind == lfpd_pkg::KIND_GOOD) ||
                         (out_kind == lfpd_pkg::KIND_BAD_TAIL);
  assign is_bad_len    = (out_kind == lfpd_pkg::KIND_BAD_LEN);
  assign is_payload    = (out_kind == lfpd_pkg::KIND_PAYLOAD);
  assign held_fields   = {out_kind, out_payload_index, out_lead_value};
  assign bad_len_clean = (out_command == 8'd0) && (out_data == 8'd0) &&
                         (out_payload_index == 16'd0) && (out_lead_value == 32'd0);
  assign end_clean     = (out_data == 8'd0) &&
                         (out_payload_index == out_frame_len - lfpd_pkg::MIN_FRAME_LEN);
  assign payload_clean = ({1'b0, out_payload_index} + 17'd6 <= {1'b0, out_frame_len}) &&
                         (out_lead_value == 32'd0);

  `LFPD_ASSERT_NXT(a_out_hold, stall, out_valid, "result dropped while stalled")
  `LFPD_ASSERT_NXT(a_out_stable, stall, $stable(held_fields), "result changed while stalled")
  `LFPD_ASSERT_NOW(a_bad_len_zero, out_valid && is_bad_len, bad_len_clean, "bad length fields")
  `LFPD_ASSERT_NOW(a_end_count, out_valid && is_end, end_clean, "frame end count mismatch")
  `LFPD_ASSERT_NOW(a_payload_range, out_valid && is_payload, payload_clean, "payload outside frame")

endmodule

bind length_framed_packet_deframer_top lfpd_checker u_lfpd_checker (.*);
`default_nettype wire

### verif/length_framed_packet_deframer_top_tb.sv
`default_nettype none
module length_framed_packet_deframer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SCRIPT_LEN     = 25;

  typedef struct packed {
    lfpd_pkg::kind_t kind;
    logic [7:0]      command;
    logic [7:0]      data;
    logic [15:0]     payload_index;
    logic [15:0]     frame_len;
    logic [31:0]     lead_value;
  } rx_record_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    bit         fixed;
    rx_record_t rec;
  } script_row_t;

  localparam rx_record_t NO_REC = '{lfpd_pkg::KIND_PAYLOAD, 8'h00, 8'h00, 16'h0000,
                                    16'h0000, 32'h0};

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic [7:0]                     in_rx_byte;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [1:0]                     out_kind;
  logic [7:0]                     out_command;
  logic [7:0]                     out_data;
  logic [15:0]                    out_payload_index;
  logic [15:0]                    out_frame_len;
  logic [31:0]                    out_lead_value;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [lfpd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [15:0]                    cfg_data;

  // deframer shadow: configuration and frame state
  logic [7:0]  sof_byte;
  logic [7:0]  eof_byte;
  logic [15:0] len_limit;
  bit          frame_open;
  logic [15:0] frame_pos;
  logic [15:0] hdr_len;
  logic [7:0]  cmd_byte;
  logic [31:0] lead_bytes;

  rx_record_t  rx_records_due [$];
  rx_record_t  want_rec;
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned ready_hold = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idle = 1'b0;

  // directed frames at reset configuration (start 0xAA, end 0xBB)
  script_row_t script [SCRIPT_LEN] = '{
    '{8'hFF, 1'b0, NO_REC},
    '{8'hAA, 1'b0, NO_REC},
    '{8'h00, 1'b0, NO_REC},
    '{8'h03, 1'b1, '{lfpd_pkg::KIND_BAD_LEN, 8'h00, 8'h00, 16'd0, 16'd3, 32'h0}},
    '{8'hAA, 1'b0, NO_REC},
    '{8'h00, 1'b0, NO_REC},
    '{8'h05, 1'b0, NO_REC},
    '{8'h7E, 1'b0, NO_REC},
    '{8'hBB, 1'b1, '{lfpd_pkg::KIND_GOOD, 8'h7E, 8'h00, 16'd0, 16'd5, 32'h0}},
    '{8'hAA, 1'b0, NO_REC},
    '{8'h00, 1'b0, NO_REC},
    '{8'h07, 1'b0, NO_REC},
    '{8'hFF, 1'b0, NO_REC},
    '{8'h12, 1'b0, NO_REC},
    '{8'hAA, 1'b0, NO_REC},
    '{8'h00, 1'b1, '{lfpd_pkg::KIND_BAD_TAIL, 8'hFF, 8'h00, 16'd2, 16'd7, 32'h0000_12AA}},
    '{8'hAA, 1'b0, NO_REC},
    '{8'h00, 1'b0, NO_REC},
    '{8'h09, 1'b0, NO_REC},
    '{8'h01, 1'b0, NO_REC},
    '{8'hDE, 1'b0, NO_REC},
    '{8'hAD, 1'b0, NO_REC},
    '{8'hBE, 1'b0, NO_REC},
    '{8'hEF, 1'b0, NO_REC},
    '{8'hBB, 1'b1, '{lfpd_pkg::KIND_GOOD, 8'h01, 8'h00, 16'd4, 16'd9, 32'hDEAD_BEEF}}
  };

  length_framed_packet_deframer_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_command      (out_command),
    .out_data         (out_data),
    .out_payload_index(out_payload_index),
    .out_frame_len    (out_frame_len),
    .out_lead_value   (out_lead_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic deframe_byte(input logic [7:0] b, output bit emit, output rx_record_t rec);
    logic [15:0]     pos;
    lfpd_pkg::kind_t end_kind;
    emit = 1'b0;
    rec = NO_REC;
    if (!frame_open) begin
      if (b == sof_byte) begin
        frame_open = 1'b1;
        frame_pos = 16'd1;
        hdr_len = 16'd0;
        cmd_byte = 8'h00;
        lead_bytes = 32'h0;
      end
    end else begin
      pos = frame_pos;
      frame_pos = frame_pos + 16'd1;
      if (pos == 16'd1) begin
        hdr_len = {b, 8'h00};
      end else if (pos == 16'd2) begin
        hdr_len[7:0] = b;
        if (hdr_len < lfpd_pkg::MIN_FRAME_LEN || hdr_len > len_limit) begin
          frame_open = 1'b0;
          emit = 1'b1;
          rec = '{lfpd_pkg::KIND_BAD_LEN, 8'h00, 8'h00, 16'd0, hdr_len, 32'h0};
        end
      end else if (pos == 16'd3) begin
        cmd_byte = b;
      end else if (pos == hdr_len - 16'd1) begin
        frame_open = 1'b0;
        emit = 1'b1;
        end_kind = lfpd_pkg::KIND_BAD_TAIL;
        if (b == eof_byte) end_kind = lfpd_pkg::KIND_GOOD;
        rec = '{end_kind, cmd_byte, 8'h00, hdr_len - lfpd_pkg::MIN_FRAME_LEN, hdr_len,
                lead_bytes};
      end else begin
        if (pos < lfpd_pkg::LEAD_END_POS) lead_bytes = {lead_bytes[23:0], b};
        emit = 1'b1;
        rec = '{lfpd_pkg::KIND_PAYLOAD, cmd_byte, b, pos - lfpd_pkg::HDR_LEN, hdr_len, 32'h0};
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input bit fixed, input rx_record_t fixed_rec);
    int unsigned gap;
    bit          emit;
    rx_record_t  rec;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    deframe_byte(b, emit, rec);
    if (fixed) rx_records_due.insert(rx_records_due.size(), fixed_rec);
    else if (emit) rx_records_due.insert(rx_records_due.size(), rec);
    if (emit || frame_open) items_sent++;
  endtask

  task automatic write_reg(input logic [lfpd_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] sof, input logic [7:0] eof,
                            input logic [15:0] lim);
    in_valid <= 1'b0;
    while (rx_records_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(lfpd_pkg::CFG_START_MARKER, {8'h00, sof});
    write_reg(lfpd_pkg::CFG_END_MARKER, {8'h00, eof});
    write_reg(lfpd_pkg::CFG_MAX_LEN, lim);
    cfg_valid <= 1'b0;
    sof_byte = sof;
    eof_byte = eof;
    len_limit = lim;
  endtask

  function automatic int unsigned pick_len();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return $urandom_range(0, 4);
    if (sel < 30 && len_limit < 16'hFFFF) return $urandom_range(int'(len_limit) + 1, 65535);
    if (len_limit < lfpd_pkg::MIN_FRAME_LEN) return $urandom_range(5, 24);
    return $urandom_range(5, (len_limit < 16'd24) ? int'(len_limit) : 24);
  endfunction

  task automatic send_frame(input int unsigned len);
    int unsigned stray;
    int unsigned p;
    logic [7:0]  b;
    logic [15:0] flen;
    flen = len[15:0];
    if ($urandom_range(0, 3) == 0) begin
      stray = $urandom_range(1, 3);
      repeat (stray) begin
        b = 8'($urandom_range(0, 255));
        if (b == sof_byte) b = ~b;
        send_byte(b, 1'b0, NO_REC);
      end
    end
    send_byte(sof_byte, 1'b0, NO_REC);
    send_byte(flen[15:8], 1'b0, NO_REC);
    send_byte(flen[7:0], 1'b0, NO_REC);
    if (flen >= lfpd_pkg::MIN_FRAME_LEN && flen <= len_limit) begin
      b = 8'($urandom_range(0, 255));
      send_byte(b, 1'b0, NO_REC);
      for (p = 4; p < int'(flen) - 1; p++) begin
        b = ($urandom_range(0, 9) == 0) ? sof_byte : 8'($urandom_range(0, 255));
        send_byte(b, 1'b0, NO_REC);
      end
      b = ($urandom_range(0, 4) != 0) ? eof_byte : 8'($urandom_range(0, 255));
      send_byte(b, 1'b0, NO_REC);
    end
  endtask

  task automatic run_frames(input int unsigned count);
    int unsigned first;
    first = items_sent;
    while (items_sent - first < count) send_frame(pick_len());
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    cfg_valid = 1'b0;
    cfg_index = lfpd_pkg::CFG_START_MARKER;
    cfg_data = 16'h0000;
    sof_byte = lfpd_pkg::START_MARKER_RST;
    eof_byte = lfpd_pkg::END_MARKER_RST;
    len_limit = lfpd_pkg::MAX_LEN_RST;
    frame_open = 1'b0;
    frame_pos = 16'd0;
    hdr_len = 16'd0;
    cmd_byte = 8'h00;
    lead_bytes = 32'h0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      send_byte(script[i].rx_byte, script[i].fixed, script[i].rec);
    end
    run_frames(150);

    set_config(8'h00, 8'hFF, 16'd5);
    run_frames(100);
    set_config(8'hFF, 8'h00, 16'hFFFE);
    run_frames(150);
    // limit below the minimum frame: every header is rejected
    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'd3);
    no_idle = 1'b1;
    run_frames(50);
    no_idle = 1'b0;
    set_config(8'h5A, 8'hA5, 16'd16);
    run_frames(200);

    in_valid <= 1'b0;
    while (rx_records_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("length_framed_packet_deframer_top test passed");
    end else begin
      $display("length_framed_packet_deframer_top test failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (rx_records_due.size() == 0) begin
          $error("unexpected request: kind %0d data 0x%02h", out_kind, out_data);
          fail_count++;
        end else begin
          want_rec = rx_records_due[0];
          rx_records_due.delete(0);
          if (out_kind != want_rec.kind) begin
            $error("kind: expected %0d, got %0d", want_rec.kind, out_kind);
            fail_count++;
          end
          if (out_command != want_rec.command) begin
            $error("command: expected 0x%02h, got 0x%02h", want_rec.command, out_command);
            fail_count++;
          end
          if (out_data != want_rec.data) begin
            $error("data: expected 0x%02h, got 0x%02h", want_rec.data, out_data);
            fail_count++;
          end
          if (out_payload_index != want_rec.payload_index) begin
            $error("payload_index: expected %0d, got %0d", want_rec.payload_index,
                   out_payload_index);
            fail_count++;
          end
          if (out_frame_len != want_rec.frame_len) begin
            $error("frame_len: expected %0d, got %0d", want_rec.frame_len, out_frame_len);
            fail_count++;
          end
          if (out_lead_value != want_rec.lead_value) begin
            $error("lead_value: expected 0x%08h, got 0x%08h", want_rec.lead_value,
                   out_lead_value);
            fail_count++;
          end
        end
        ready_hold = no_idle ? 0 : $urandom_range(0, 7);
      end else if (ready_hold != 0) begin
        ready_hold--;
      end
      out_ready <= (ready_hold == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("length_framed_packet_deframer_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
`default_nettype wire

### sim.f
+incdir+hw/rtl
hw/rtl/lfpd_pkg.sv
hw/rtl/lfpd_front.sv
hw/rtl/lfpd_queue.sv
hw/rtl/lfpd_back.sv
hw/rtl/length_framed_packet_deframer_top.sv
hw/rtl/lfpd_checker.sv
verif/length_framed_packet_deframer_top_tb.sv
